// ===== sv/modexp_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
// No dependencies; imported by modexp_mulmod and modular_exponentiation.
`default_nettype none

package modexp_pkg;

   localparam int OPERAND_BITS_DEFAULT = 31;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/modexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: a * b mod m, one multiplier bit per cycle.
// Depends on modexp_pkg. Requires b < m; a may take any value.
`default_nettype none

module modexp_mulmod
   import modexp_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [OPERAND_BITS-1:0] op_a,
   input  wire logic [OPERAND_BITS-1:0] op_b,
   input  wire logic [OPERAND_BITS-1:0] modulus,
   output logic                         done,
   output logic [OPERAND_BITS-1:0]      product
);

   localparam int W      = OPERAND_BITS + 2;
   localparam int CNT_W  = $clog2(OPERAND_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [OPERAND_BITS-1:0] a_sh_ff, a_sh_in;
   logic [OPERAND_BITS-1:0] b_ff, b_in;
   logic [OPERAND_BITS-1:0] p_ff, p_in;

   logic [W-1:0] sum, m1, m2, red;

   // Partial result stays below m, so 2p + b is below 3m and at most two
   // subtractions of m bring it back into range.
   always_comb begin
      sum = {1'b0, p_ff, 1'b0} + (a_sh_ff[OPERAND_BITS-1] ? {2'b00, b_ff} : W'(0));
      m1  = {2'b00, modulus};
      m2  = {1'b0, modulus, 1'b0};
      if (sum >= m2) begin
         red = sum - m2;
      end else if (sum >= m1) begin
         red = sum - m1;
      end else begin
         red = sum;
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sh_in = a_sh_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         a_sh_in = op_a;
         b_in    = op_b;
         p_in    = '0;
      end else if (run_ff) begin
         p_in    = red[OPERAND_BITS-1:0];
         a_sh_in = {a_sh_ff[OPERAND_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_sh_ff <= a_sh_in;
      b_ff    <= b_in;
      p_ff    <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// Modular exponentiation: result = block^exponent mod modulus, left-to-right
// square-and-multiply over one shared bit-serial multiplier (N = OPERAND_BITS).
// The shared serial multiplier carries the reduction, every squaring and every
// multiplication for the one bits of the exponent, and it sets the throughput.
// Exponent zero, or modulus of zero or one, answers in the cycle after start. One item at a time.
// Synchronous reset sets modulus and exponent to 1 and idles the block.
`default_nettype none

module modular_exponentiation
   import modexp_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [OPERAND_BITS-1:0]   req_block_value,
   output logic                           rsp_valid,
   output logic [OPERAND_BITS-1:0]        rsp_transformed_block,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [OPERAND_BITS-1:0]   csr_wdata
);

   localparam int BIT_W = $clog2(OPERAND_BITS);
   localparam logic [OPERAND_BITS-1:0] ONE = OPERAND_BITS'(1);

   state_type               state_ff, state_in;
   logic [OPERAND_BITS-1:0] modulus_ff, exponent_ff;
   logic [OPERAND_BITS-1:0] acc_ff, acc_in;
   logic [OPERAND_BITS-1:0] base_ff, base_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                    mul_start, mul_done;
   logic [OPERAND_BITS-1:0] mul_a, mul_b, mul_product;

   modexp_mulmod #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= ONE;
         exponent_ff <= ONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:  modulus_ff  <= csr_wdata;
            CSR_EXPONENT: exponent_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      bit_in       = bit_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_a        = mul_product;
      mul_b        = mul_product;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (exponent_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = ONE;
               end else if (modulus_ff <= ONE) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  // Reduce the block first: block * 1 mod m.
                  mul_start = 1'b1;
                  mul_a     = req_block_value;
                  mul_b     = ONE;
                  acc_in    = ONE;
                  bit_in    = BIT_W'(OPERAND_BITS - 1);
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in   = mul_product;
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = acc_ff;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (exponent_ff[bit_ff]) begin
                  mul_start = 1'b1;
                  mul_b     = base_ff;
                  state_in  = ST_MULT;
               end else if (bit_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mul_product;
                  state_in     = ST_IDLE;
               end else begin
                  bit_in    = bit_ff - BIT_W'(1);
                  mul_start = 1'b1;
               end
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (bit_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mul_product;
                  state_in     = ST_IDLE;
               end else begin
                  bit_in    = bit_ff - BIT_W'(1);
                  mul_start = 1'b1;
                  state_in  = ST_SQUARE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_transformed_block = rsp_data_ff;

endmodule

`default_nettype wire

// ===== test/modular_exponentiation_tb.sv =====
// Self-checking testbench for modular_exponentiation (block^exponent mod modulus).
// Depends on modexp_pkg for the register indexes; a scoreboard class predicts each result.
`default_nettype none

module modular_exponentiation_tb
   import modexp_pkg::*;
();

   localparam int W = OPERAND_BITS_DEFAULT;
   // Slowest item: every exponent bit set, one serial multiplication per step.
   localparam int LATENCY_MAX = (W + 1) * (2 * W + 1) + 1;
   localparam int BLOCK_COUNT = 290;
   localparam longint CYCLE_LIMIT = 10000000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef logic [W-1:0] operand_type;
   localparam operand_type OPERAND_MAX = '1;
   localparam operand_type PUBLIC_EXPONENT = 65537;

   class block_transform_tracker_type;
      operand_type modulus_key;
      operand_type exponent_key;
      operand_type expected_blocks[$];
      int unsigned error_count;

      function new();
         modulus_key = 1;
         exponent_key = 1;
         error_count = 0;
      endfunction

      function void write_key(logic [CSR_INDEX_BITS-1:0] index, operand_type value);
         case (index)
            CSR_MODULUS: begin
               modulus_key = value;
            end
            CSR_EXPONENT: begin
               exponent_key = value;
            end
            default: begin
            end
         endcase
      endfunction

      function operand_type power_mod(operand_type blk);
         logic [63:0] acc;
         logic [63:0] base;
         logic [63:0] m;
         if (exponent_key == 0)
            return 1;
         if (modulus_key == 0)
            return 0;
         m = modulus_key;
         base = blk % m;
         acc = 1 % m;
         for (int b = W - 1; b >= 0; b--) begin
            acc = (acc * acc) % m;
            if (exponent_key[b])
               acc = (acc * base) % m;
         end
         return acc[W-1:0];
      endfunction

      function void note_block(operand_type blk);
         expected_blocks.insert(expected_blocks.size(), power_mod(blk));
      endfunction

      function void check_result(operand_type actual);
         operand_type expected;
         if (expected_blocks.size() == 0) begin
            $error("transformed_block with no block pending: actual %0d", actual);
            error_count++;
            return;
         end
         expected = expected_blocks.pop_front();
         if (actual !== expected) begin
            $error("transformed_block mismatch: expected %0d, actual %0d", expected, actual);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_blocks.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   operand_type req_block_value = '0;
   logic rsp_valid;
   operand_type rsp_transformed_block;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MODULUS;
   operand_type csr_wdata = '0;

   block_transform_tracker_type tracker = new();
   int unsigned blocks_sent = 0;
   longint cycle_count = 0;

   modular_exponentiation #(.OPERAND_BITS(W)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_block_value(req_block_value),
      .rsp_valid(rsp_valid),
      .rsp_transformed_block(rsp_transformed_block),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_result(rsp_transformed_block);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("modular_exponentiation_tb: FAIL");
         $finish;
      end
   end

   // Start stays high from one transfer to the next when there is no gap.
   task automatic send_block(operand_type blk);
      req_block_value <= blk;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_block(blk);
      blocks_sent++;
   endtask

   task automatic pause_sender(int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds off new blocks until every expected result has come back.
   task automatic settle();
      start <= 1'b0;
      while (tracker.pending() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index, operand_type value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_key(index, value);
      @(posedge clock);
   endtask

   task automatic load_keys(operand_type modulus_value, operand_type exponent_value);
      settle();
      write_register(CSR_MODULUS, modulus_value);
      write_register(CSR_EXPONENT, exponent_value);
   endtask

   function automatic int unsigned pick_gap(bit burst);
      int unsigned roll;
      if (burst)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return 0;
      if (roll < 80)
         return $urandom_range(1, 8);
      if (roll < 96)
         return $urandom_range(9, 200);
      return $urandom_range(201, 2500);
   endfunction

   function automatic operand_type pick_modulus();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return OPERAND_MAX;
      if (roll < 16)
         return 1;
      if (roll < 20)
         return 0;
      if (roll < 45)
         return operand_type'($urandom_range(2, 1000));
      return operand_type'($urandom_range(2, OPERAND_MAX));
   endfunction

   function automatic operand_type pick_exponent();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         return PUBLIC_EXPONENT;
      if (roll < 33)
         return 0;
      if (roll < 43)
         return OPERAND_MAX;
      if (roll < 58)
         return operand_type'($urandom_range(1, 16));
      return operand_type'($urandom_range(0, OPERAND_MAX));
   endfunction

   function automatic operand_type pick_block(operand_type modulus_value);
      int unsigned roll;
      operand_type one_less;
      roll = $urandom_range(0, 99);
      one_less = modulus_value - operand_type'(1);
      if (roll < 45)
         return operand_type'($urandom_range(0, OPERAND_MAX));
      if (roll < 65)
         return (modulus_value == 0) ? operand_type'($urandom)
                                     : operand_type'($urandom_range(0, one_less));
      if (roll < 75)
         return operand_type'($urandom_range(0, 1));
      if (roll < 85)
         return OPERAND_MAX;
      if (roll < 95)
         return $urandom_range(0, 1) ? modulus_value : one_less;
      return operand_type'(1) << $urandom_range(0, W - 1);
   endfunction

   initial begin
      operand_type modulus_value;
      int unsigned phase_blocks;
      bit burst;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Keys straight out of reset: modulus one, so every block maps to zero.
      send_block(0);
      send_block(OPERAND_MAX);
      send_block(5);

      load_keys(OPERAND_MAX, OPERAND_MAX);
      send_block(0);
      send_block(1);
      send_block(OPERAND_MAX);
      send_block(OPERAND_MAX - operand_type'(1));
      send_block(2);
      send_block(31'h5555_5555);
      send_block(31'h2AAA_AAAA);

      // A zero exponent answers one regardless of block or modulus.
      load_keys(OPERAND_MAX, 0);
      send_block(0);
      send_block(OPERAND_MAX);

      load_keys(0, 5);
      send_block(7);
      send_block(OPERAND_MAX);
      load_keys(0, 0);
      send_block(7);
      load_keys(1, 0);
      send_block(3);

      // Writes to unused indexes must leave both keys alone.
      load_keys(1000003, PUBLIC_EXPONENT);
      write_register(CSR_SPARE_A, OPERAND_MAX);
      write_register(CSR_SPARE_B, 0);
      send_block(2000000000);
      send_block(12345);
      send_block(1000003);
      load_keys(2, 1);
      send_block(OPERAND_MAX);
      send_block(6);

      while (blocks_sent < BLOCK_COUNT) begin
         modulus_value = pick_modulus();
         load_keys(modulus_value, pick_exponent());
         if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                           operand_type'($urandom_range(0, OPERAND_MAX)));
         phase_blocks = $urandom_range(6, 24);
         burst = ($urandom_range(0, 3) == 0);
         repeat (phase_blocks) begin
            send_block(pick_block(modulus_value));
            pause_sender(pick_gap(burst));
         end
      end

      settle();
      repeat (LATENCY_MAX) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("transformed_block results missing: %0d still expected", tracker.pending());
         tracker.error_count++;
      end
      if (tracker.error_count == 0)
         $display("modular_exponentiation_tb: PASS");
      else
         $display("modular_exponentiation_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
